### src/msla_pkg.sv
// Shared types and constants for the mean squared loss with accuracy unit.
// Used by the controller, the datapath and the top level; no dependencies.
package msla_pkg;

	localparam int MAX_ROW_LEN = 1024;
	localparam int MAX_BATCH   = 1024;

	localparam int DATA_W = 16;
	localparam int PROD_W = 2 * DATA_W;
	localparam int SUM_W  = 43;
	localparam int IDX_W  = 10;
	localparam int CNT_W  = 11;
	localparam int DIV_W  = 11;

	localparam int INDEX_CAP = (MAX_ROW_LEN - 1) < 1023 ? (MAX_ROW_LEN - 1) : 1023;
	localparam int COUNT_CAP = MAX_BATCH < 2047 ? MAX_BATCH : 2047;

	localparam int DIV_STEPS = SUM_W;
	localparam int STEP_W    = $clog2(DIV_STEPS);

	localparam logic [SUM_W-1:0] SUM_MAX = '1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SQUARE,
		ST_ACCUM,
		ST_DIVIDE,
		ST_FINISH,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic accept;
		logic square;
		logic accum;
		logic div_load;
		logic div_step;
		logic finish;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic end_row;
		logic end_batch;
		logic div_done;
		logic out_busy;
	} status_t;

endpackage

### src/msla_ctrl.sv
// Sequencer for the loss unit: steps one request through square and accumulate,
// at a row's end divide and finish, at a batch's end emit. Depends on msla_pkg.
module msla_ctrl import msla_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_stall,
	input  status_t status,
	output cmd_t    cmd
);

	state_t state_q;
	state_t state_next;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	// next state
	always_comb begin
		state_next = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) state_next = ST_SQUARE;
			end
			ST_SQUARE: begin
				state_next = ST_ACCUM;
			end
			ST_ACCUM: begin
				state_next = status.end_row ? ST_DIVIDE : ST_IDLE;
			end
			ST_DIVIDE: begin
				if (status.div_done) state_next = ST_FINISH;
			end
			ST_FINISH: begin
				state_next = status.end_batch ? ST_EMIT : ST_IDLE;
			end
			ST_EMIT: begin
				if (!status.out_busy) state_next = ST_IDLE;
			end
			default: begin
				state_next = ST_IDLE;
			end
		endcase
	end

	// commands to the datapath
	always_comb begin
		cmd      = '0;
		in_stall = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				in_stall   = 1'b0;
				cmd.accept = in_valid;
			end
			ST_SQUARE: begin
				cmd.square = 1'b1;
			end
			ST_ACCUM: begin
				cmd.accum    = 1'b1;
				cmd.div_load = status.end_row;
			end
			ST_DIVIDE: begin
				cmd.div_step = 1'b1;
			end
			ST_FINISH: begin
				cmd.finish = 1'b1;
			end
			ST_EMIT: begin
				cmd.emit = !status.out_busy;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	// a divide always runs its full step count before the row is closed
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIVIDE && !status.div_done) |=> state_q == ST_DIVIDE)
		else $error("divide left before the last step");

	// only one request is in flight between accept and return to idle
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.accept |=> (in_stall && state_q == ST_SQUARE))
		else $error("second request taken while one is in flight");

	// an emit never overwrites a result that is still waiting
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> !status.out_busy)
		else $error("result register overwritten");

endmodule

### src/msla_dp.sv
// Datapath of the loss unit: squared error, row accumulation, argmax tracking,
// restoring divider, loss and match totals, result register. Depends on msla_pkg.
module msla_dp import msla_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  cmd_t                     cmd,
	output status_t                  status,
	input  logic signed [DATA_W-1:0] prediction,
	input  logic signed [DATA_W-1:0] target,
	input  logic                     last_in_row,
	input  logic                     last_in_batch,
	input  logic                     batch_rows_wr_en,
	input  logic [DIV_W-1:0]         batch_rows_wr_data,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic [SUM_W-1:0]         loss,
	output logic [CNT_W-1:0]         correct_count
);

	logic [DIV_W-1:0]         batch_rows_q;
	logic signed [DATA_W-1:0] pred_s1;
	logic signed [DATA_W-1:0] targ_s1;
	logic                     end_row_s1;
	logic                     end_batch_s1;
	logic [DATA_W-1:0]        abs_diff_s1;
	logic [PROD_W-1:0]        prod_s2;

	logic [SUM_W-1:0]         row_sum_q;
	logic [IDX_W-1:0]         elem_idx_q;
	logic signed [DATA_W-1:0] best_pred_q;
	logic [IDX_W-1:0]         best_pred_idx_q;
	logic signed [DATA_W-1:0] best_targ_q;
	logic [IDX_W-1:0]         best_targ_idx_q;
	logic [SUM_W-1:0]         loss_q;
	logic [CNT_W-1:0]         match_q;

	logic [SUM_W-1:0]         quo_q;
	logic [DIV_W-1:0]         rem_q;
	logic [STEP_W-1:0]        step_q;

	logic                     out_valid_q;
	logic [SUM_W-1:0]         loss_out_q;
	logic [CNT_W-1:0]         count_out_q;

	logic signed [DATA_W:0]   diff;
	logic [DATA_W:0]          diff_mag;
	logic [SUM_W:0]           row_sum_ext;
	logic [SUM_W-1:0]         row_sum_next;
	logic [SUM_W:0]           loss_ext;
	logic [DIV_W-1:0]         divisor;
	logic [DIV_W:0]           trial;
	logic                     trial_ge;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			batch_rows_q <= DIV_W'(1);
		end else if (batch_rows_wr_en) begin
			batch_rows_q <= batch_rows_wr_data;
		end
	end

	// absolute difference of the incoming pair
	always_comb begin
		diff     = {prediction[DATA_W-1], prediction} - {target[DATA_W-1], target};
		diff_mag = diff[DATA_W] ? (DATA_W + 1)'(0) - diff : diff;
	end

	// request capture and squaring
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			pred_s1      <= prediction;
			targ_s1      <= target;
			end_row_s1   <= last_in_row | last_in_batch;
			end_batch_s1 <= last_in_batch;
			abs_diff_s1  <= diff_mag[DATA_W-1:0];
		end
		if (cmd.square) begin
			prod_s2 <= abs_diff_s1 * abs_diff_s1;
		end
	end

	// saturating row sum
	always_comb begin
		row_sum_ext  = {1'b0, row_sum_q} + {{(SUM_W + 1 - PROD_W){1'b0}}, prod_s2};
		row_sum_next = row_sum_ext[SUM_W] ? SUM_MAX : row_sum_ext[SUM_W-1:0];
		loss_ext     = {1'b0, loss_q} + {1'b0, quo_q};
	end

	// row state: sum, element index and first maxima
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_sum_q       <= '0;
			elem_idx_q      <= '0;
			best_pred_q     <= '0;
			best_pred_idx_q <= '0;
			best_targ_q     <= '0;
			best_targ_idx_q <= '0;
		end else if (cmd.finish) begin
			row_sum_q       <= '0;
			elem_idx_q      <= '0;
			best_pred_q     <= '0;
			best_pred_idx_q <= '0;
			best_targ_q     <= '0;
			best_targ_idx_q <= '0;
		end else if (cmd.accum) begin
			row_sum_q <= row_sum_next;
			if (elem_idx_q == '0 || pred_s1 > best_pred_q) begin
				best_pred_q     <= pred_s1;
				best_pred_idx_q <= elem_idx_q;
			end
			if (elem_idx_q == '0 || targ_s1 > best_targ_q) begin
				best_targ_q     <= targ_s1;
				best_targ_idx_q <= elem_idx_q;
			end
			if (elem_idx_q < IDX_W'(INDEX_CAP)) begin
				elem_idx_q <= elem_idx_q + IDX_W'(1);
			end
		end
	end

	// restoring divider, one quotient bit per cycle
	always_comb begin
		divisor  = (batch_rows_q == '0) ? DIV_W'(1) : batch_rows_q;
		trial    = {rem_q, quo_q[SUM_W-1]};
		trial_ge = trial >= {1'b0, divisor};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quo_q  <= '0;
			rem_q  <= '0;
			step_q <= '0;
		end else if (cmd.div_load) begin
			quo_q  <= row_sum_next;
			rem_q  <= '0;
			step_q <= '0;
		end else if (cmd.div_step) begin
			quo_q  <= {quo_q[SUM_W-2:0], trial_ge};
			rem_q  <= trial_ge ? DIV_W'(trial - {1'b0, divisor}) : trial[DIV_W-1:0];
			step_q <= step_q + STEP_W'(1);
		end
	end

	// batch totals
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			loss_q  <= '0;
			match_q <= '0;
		end else if (cmd.emit) begin
			loss_q  <= '0;
			match_q <= '0;
		end else if (cmd.finish) begin
			loss_q <= loss_ext[SUM_W] ? SUM_MAX : loss_ext[SUM_W-1:0];
			if (best_pred_idx_q == best_targ_idx_q && match_q < CNT_W'(COUNT_CAP)) begin
				match_q <= match_q + CNT_W'(1);
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			loss_out_q  <= loss_q;
			count_out_q <= match_q;
		end
	end

	// status back to the controller
	always_comb begin
		status.end_row   = end_row_s1;
		status.end_batch = end_batch_s1;
		status.div_done  = step_q == STEP_W'(DIV_STEPS - 1);
		status.out_busy  = out_valid_q & out_stall;
	end

	assign out_valid     = out_valid_q;
	assign loss          = loss_out_q;
	assign correct_count = count_out_q;

	// partial remainder stays below the divisor through a divide
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_step |-> rem_q < divisor)
		else $error("divider remainder out of range");

	// match count never passes its cap
	assert property (@(posedge clk) disable iff (!arst_n)
		match_q <= CNT_W'(COUNT_CAP))
		else $error("match count above cap");

	// an emit presents the result and leaves the totals cleared
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |=> (out_valid_q && loss_q == '0 && match_q == '0))
		else $error("emit did not present result or clear totals");

endmodule

### src/mean_squared_loss_with_accuracy_unit.sv
// Top level of the mean squared loss with accuracy unit.
// Joins msla_ctrl and msla_dp; depends on msla_pkg.

// Takes one prediction/target pair (signed Q4.12) per request and sums the
// squared errors of a row in Q19.24, saturating at 2^43-1. An ordinary element
// goes from one accept to the next through capture, square and accumulate.
// The element that ends a row goes on: the row sum then passes through a
// restoring divider that produces one quotient bit per cycle over 43 bits,
// then the finish state adds it to the loss and scores the argmax match.
// The element that ends a batch then loads the result register in the emit
// state, which waits while the previous result is still stalled at the output.
// A batch_rows of zero divides by one. Write batch_rows only while idle.
module mean_squared_loss_with_accuracy_unit import msla_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     batch_rows_wr_en,
	input  logic [DIV_W-1:0]         batch_rows_wr_data,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic signed [DATA_W-1:0] prediction,
	input  logic signed [DATA_W-1:0] target,
	input  logic                     last_in_row,
	input  logic                     last_in_batch,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic [SUM_W-1:0]         loss,
	output logic [CNT_W-1:0]         correct_count
);

	cmd_t    cmd;
	status_t status;

	// sequencer
	msla_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.status   (status),
		.cmd      (cmd)
	);

	// arithmetic and state
	msla_dp u_dp (
		.clk                (clk),
		.arst_n             (arst_n),
		.cmd                (cmd),
		.status             (status),
		.prediction         (prediction),
		.target             (target),
		.last_in_row        (last_in_row),
		.last_in_batch      (last_in_batch),
		.batch_rows_wr_en   (batch_rows_wr_en),
		.batch_rows_wr_data (batch_rows_wr_data),
		.out_valid          (out_valid),
		.out_stall          (out_stall),
		.loss               (loss),
		.correct_count      (correct_count)
	);

endmodule
